@@ hw/rtl/mewt_pkg.sv @@
// Shared types and constants for the motion event window trigger.
package mewt_pkg;

	localparam int STAMP_W    = 32;
	localparam int COUNT_W    = 9;
	localparam int MIN_W      = 8;
	localparam int WIN_W      = 16;
	localparam int LIMIT_W    = 27;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam int COUNT_FIELD_MAX = 511;
	localparam logic [9:0] MS_PER_SECOND = 10'd1000;

	localparam logic OP_EVENT = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_EVENTS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW     = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_CHECK,
		ST_DONE
	} mewt_state_t;

endpackage

@@ hw/rtl/mewt_store.sv @@
// Timestamp store: one write port, one read port with registered data.
module mewt_store #(
	parameter int DEPTH  = 256,
	parameter int DATA_W = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_W-1:0]        wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/motion_event_window_trigger_unit.sv @@
// Motion event window trigger: ring of event stamps, expiry scan, fix request flag.
// Timing: query or inactive item -> result registered in the cycle after the transfer.
//   Motion event -> entries are scanned newest first (at most stored count + 1); each entry
//   takes a read state (ST_READ) and a compare state (ST_CHECK) on the shared subtractor.
// Throughput: one item at a time; in_stall is high from transfer until the result is loaded.
// Reset: counters, pointer, pending flag and config clear; store contents stay undefined.
module motion_event_window_trigger_unit #(
	parameter int MAX_EVENTS = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           op,
	input  logic [mewt_pkg::STAMP_W-1:0]   now_ms,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           accepted,
	output logic [mewt_pkg::COUNT_W-1:0]   event_count,
	output logic                           fix_request,
	input  logic                           cfg_we,
	input  logic [mewt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mewt_pkg::CFG_DATA_W-1:0] cfg_data
);

	import mewt_pkg::*;

	// Pointer indexes the ring; count must hold MAX_EVENTS itself.
	localparam int PTR_W = $clog2(MAX_EVENTS);
	localparam int CNT_W = $clog2(MAX_EVENTS + 1);
	localparam int SUM_W = CNT_W + 1;
	localparam int EXT_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
	localparam int CMP_W = (CNT_W > MIN_W) ? CNT_W : MIN_W;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_EVENTS);
	localparam logic [SUM_W-1:0] MAX_SUM = SUM_W'(MAX_EVENTS);

	// Ring slot of the k-th entry after base; base + k stays below twice the depth.
	function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] base,
	                                             input logic [CNT_W-1:0] k);
		logic [SUM_W-1:0] s;
		s = SUM_W'(base) + SUM_W'(k);
		if (s >= MAX_SUM) begin
			s = s - MAX_SUM;
		end
		return s[PTR_W-1:0];
	endfunction

	// Count field of a result saturates at its 9-bit maximum.
	function automatic logic [COUNT_W-1:0] sat_count(input logic [CNT_W-1:0] n);
		logic [EXT_W-1:0] e;
		e = EXT_W'(n);
		if (e > EXT_W'(COUNT_FIELD_MAX)) begin
			e = EXT_W'(COUNT_FIELD_MAX);
		end
		return e[COUNT_W-1:0];
	endfunction

	// Config registers. limit_q = (window + 1) * 1000 ms: an entry is expired when
	// floor(age_ms / 1000) > window, i.e. age_ms >= limit, so no divider is needed.
	logic               enable_q;
	logic [MIN_W-1:0]   min_q;
	logic [WIN_W-1:0]   window_q;
	logic [LIMIT_W-1:0] limit_q;

	// Ring state
	logic [PTR_W-1:0]   oldest_q;
	logic [CNT_W-1:0]   count_q;
	logic               pending_q;

	// Scan sequencer
	mewt_state_t        state_q, state_d;
	logic [CNT_W-1:0]   k_q;
	logic [CNT_W-1:0]   kept_q;
	logic [STAMP_W-1:0] now_q;

	// Output register
	logic               out_valid_q;
	logic               accepted_q;
	logic [COUNT_W-1:0] event_count_q;
	logic               fix_request_q;

	// Store port signals
	logic               ram_we;
	logic [PTR_W-1:0]   ram_waddr;
	logic [PTR_W-1:0]   ram_raddr;
	logic [STAMP_W-1:0] ram_rdata;

	logic               in_xfer;
	logic               out_free;
	logic               active;
	logic               full;
	logic               expired;
	logic               reached;
	logic [STAMP_W-1:0] age_ms;
	logic               ld_out;
	logic               ld_accepted;
	logic [COUNT_W-1:0] ld_count;
	logic               ld_fix;

	assign active   = enable_q && (min_q != '0) && (window_q != '0);
	assign full     = (count_q == MAX_CNT);
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign in_xfer  = in_valid && !in_stall;

	// Shared subtract/compare: age of the entry just read, against the window limit.
	assign age_ms  = now_q - ram_rdata;
	assign expired = (age_ms >= STAMP_W'(limit_q));
	assign reached = (CMP_W'(kept_q) >= CMP_W'(min_q));

	// When full, the new stamp overwrites the oldest slot and the ring advances by one.
	assign ram_waddr = full ? oldest_q : slot_of(oldest_q, count_q);
	assign ram_raddr = slot_of(oldest_q, k_q - CNT_W'(1));

	mewt_store #(
		.DEPTH  (MAX_EVENTS),
		.DATA_W (STAMP_W)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (now_ms),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, store write and result load
	always_comb begin
		state_d     = state_q;
		ram_we      = 1'b0;
		ld_out      = 1'b0;
		ld_accepted = 1'b0;
		ld_count    = sat_count(count_q);
		ld_fix      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					if (!active) begin
						ld_out = 1'b1;
					end else if (op == OP_QUERY) begin
						ld_out      = 1'b1;
						ld_accepted = 1'b1;
						ld_fix      = pending_q;
					end else begin
						ram_we  = 1'b1;
						state_d = ST_READ;
					end
				end
			end
			ST_READ: begin
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				// stop at the first expired entry or after the oldest one
				if (expired || (k_q == CNT_W'(1))) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_READ;
				end
			end
			ST_DONE: begin
				ld_accepted = 1'b1;
				ld_count    = sat_count(kept_q);
				ld_fix      = reached;
				if (out_free) begin
					ld_out  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= 1'b0;
			min_q       <= '0;
			window_q    <= '0;
			limit_q     <= LIMIT_W'(MS_PER_SECOND);
			oldest_q    <= '0;
			count_q     <= '0;
			pending_q   <= 1'b0;
			k_q         <= '0;
			kept_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ENABLE:     enable_q <= cfg_data[0];
					REG_MIN_EVENTS: min_q    <= cfg_data[MIN_W-1:0];
					REG_WINDOW: begin
						window_q <= cfg_data[WIN_W-1:0];
						limit_q  <= (LIMIT_W'(cfg_data[WIN_W-1:0]) + LIMIT_W'(1))
						            * LIMIT_W'(MS_PER_SECOND);
					end
					default: ;
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer && active) begin
						if (op == OP_QUERY) begin
							pending_q <= 1'b0;
						end else begin
							// append; a full ring drops its oldest entry first
							if (full) begin
								oldest_q <= slot_of(oldest_q, CNT_W'(1));
								count_q  <= MAX_CNT;
								k_q      <= MAX_CNT;
							end else begin
								count_q <= count_q + CNT_W'(1);
								k_q     <= count_q + CNT_W'(1);
							end
							kept_q <= '0;
						end
					end
				end
				ST_READ: ;
				ST_CHECK: begin
					if (!expired) begin
						kept_q <= kept_q + CNT_W'(1);
						k_q    <= k_q - CNT_W'(1);
					end
				end
				ST_DONE: begin
					if (out_free) begin
						if (reached) begin
							// threshold hit: flag the fix and empty the ring
							pending_q <= 1'b1;
							oldest_q  <= '0;
							count_q   <= '0;
						end else begin
							oldest_q <= slot_of(oldest_q, count_q - kept_q);
							count_q  <= kept_q;
						end
					end
				end
				default: ;
			endcase

			if (ld_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			now_q <= now_ms;
		end
		if (ld_out) begin
			accepted_q    <= ld_accepted;
			event_count_q <= ld_count;
			fix_request_q <= ld_fix;
		end
	end

	assign out_valid   = out_valid_q;
	assign accepted    = accepted_q;
	assign event_count = event_count_q;
	assign fix_request = fix_request_q;

endmodule

@@ tb/tb_motion_event_window_trigger_unit.sv @@
// Self-checking testbench for the motion event window trigger unit.
module tb_motion_event_window_trigger_unit;
	import mewt_pkg::*;

	// Ring depth of the unit under test; the shadow ring below matches it.
	localparam int DEPTH = 256;
	// Register index that decodes to nothing; writes to it must be dropped.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	// Items sent in the random part, and the point after which idling stops.
	localparam int RANDOM_ITEMS = 1620;
	localparam int CALM_AFTER = 1500;
	// Slowest event scans the whole ring; the drain wait covers it, plus slack.
	localparam int DRAIN_CYCLES = 2 * DEPTH + 16;

	// One result transfer as seen on the output side.
	typedef struct packed {
		logic                accepted;
		logic [COUNT_W-1:0]  count;
		logic                fix;
	} answer_t;

	// One row of the directed plan: a register write or an input transfer.
	// Rows with typed set carry their answer inline; the rest use the shadow model.
	typedef struct packed {
		logic                  is_reg;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		logic                  op;
		logic [STAMP_W-1:0]    stamp;
		logic                  typed;
		answer_t               want;
	} plan_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  op = OP_EVENT;
	logic [STAMP_W-1:0]    now_ms = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  accepted;
	logic [COUNT_W-1:0]    event_count;
	logic                  fix_request;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_ENABLE;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Shadow copy of the unit: stamp ring, head slot, occupancy, pending flag.
	logic [STAMP_W-1:0] stamp_mem [DEPTH];
	int                 head_slot = 0;
	int                 held_count = 0;
	logic               fix_pending = 1'b0;
	logic               cfg_enable = 1'b0;
	logic [MIN_W-1:0]   cfg_min = '0;
	logic [WIN_W-1:0]   cfg_window = '0;

	// Answers still owed by the unit, oldest first.
	answer_t answer_q [$];
	int      mismatches = 0;
	logic    calm = 1'b0;
	int      stall_hold = 0;

	motion_event_window_trigger_unit #(
		.MAX_EVENTS(DEPTH)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.now_ms     (now_ms),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.accepted   (accepted),
		.event_count(event_count),
		.fix_request(fix_request),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #5 clk = ~clk;

	// The feature only acts with enable set and both thresholds nonzero.
	function automatic logic feature_live();
		return cfg_enable && cfg_min != 0 && cfg_window != 0;
	endfunction

	// Shadow model step: updates the ring and returns the answer for one transfer.
	function automatic answer_t scan_window(logic op_i, logic [STAMP_W-1:0] t);
		answer_t            a;
		int                 kept;
		int                 k;
		logic [STAMP_W-1:0] age_ms;
		a.accepted = 1'b0;
		a.count = COUNT_W'(held_count);
		a.fix = 1'b0;
		// Inactive: nothing moves, the stored count is reported as is.
		if (!feature_live())
			return a;
		a.accepted = 1'b1;
		// Query hands out the pending request and consumes it.
		if (op_i == OP_QUERY) begin
			a.fix = fix_pending;
			fix_pending = 1'b0;
			return a;
		end
		// A full ring gives up its oldest stamp before the new one goes in.
		if (held_count >= DEPTH) begin
			head_slot = (head_slot + 1) % DEPTH;
			held_count = DEPTH - 1;
		end
		stamp_mem[(head_slot + held_count) % DEPTH] = t;
		held_count++;
		// Walk newest to oldest; the first stale stamp cuts off itself and all older.
		// Age is the wrapped 32-bit difference in ms, compared in whole seconds.
		kept = 0;
		for (k = held_count; k > 0; k--) begin
			age_ms = t - stamp_mem[(head_slot + k - 1) % DEPTH];
			if (age_ms / MS_PER_SECOND > cfg_window)
				break;
			kept++;
		end
		head_slot = (head_slot + held_count - kept) % DEPTH;
		held_count = kept;
		a.count = COUNT_W'(kept);
		// Threshold reached: raise the request and empty the ring.
		if (kept >= cfg_min) begin
			fix_pending = 1'b1;
			head_slot = 0;
			held_count = 0;
			a.fix = 1'b1;
		end
		return a;
	endfunction

	function automatic plan_row_t item_row(logic o, logic [STAMP_W-1:0] t, logic typed,
		logic a, logic [COUNT_W-1:0] c, logic f);
		plan_row_t r;
		r = '0;
		r.op = o;
		r.stamp = t;
		r.typed = typed;
		r.want.accepted = a;
		r.want.count = c;
		r.want.fix = f;
		return r;
	endfunction

	function automatic plan_row_t reg_row(logic [CFG_IDX_W-1:0] i, logic [CFG_DATA_W-1:0] d);
		plan_row_t r;
		r = '0;
		r.is_reg = 1'b1;
		r.idx = i;
		r.data = d;
		return r;
	endfunction

	task automatic flag_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] exp_v);
		mismatches++;
		if (mismatches <= 100)
			$display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, exp_v);
	endtask

	// Register write: one cycle with cfg_we high, shadow copy follows the same masks.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_ENABLE: begin
				cfg_enable = d[0];
			end
			REG_MIN_EVENTS: begin
				cfg_min = d[MIN_W-1:0];
			end
			REG_WINDOW: begin
				cfg_window = d[WIN_W-1:0];
			end
			default: begin
			end
		endcase
		@(posedge clk);
	endtask

	// Hold valid high until a transfer, then record what the unit owes for it.
	task automatic send_item(input logic o, input logic [STAMP_W-1:0] t, input logic typed,
		input answer_t want);
		answer_t predicted;
		in_valid <= 1'b1;
		op <= o;
		now_ms <= t;
		do @(posedge clk); while (in_stall);
		predicted = scan_window(o, t);
		answer_q.push_back(typed ? want : predicted);
	endtask

	task automatic pause_input(input int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Quiet the input and wait for every owed answer; registers only change then.
	task automatic settle();
		in_valid <= 1'b0;
		while (answer_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Receiver stall: random bursts between runs of free flow; none once calm.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_hold <= 0;
		end else if (calm) begin
			out_stall <= 1'b0;
		end else if (stall_hold != 0) begin
			stall_hold <= stall_hold - 1;
		end else if (out_stall) begin
			out_stall <= 1'b0;
			stall_hold <= ($urandom_range(0, 7) == 0) ? $urandom_range(50, 300)
				: $urandom_range(0, 40);
		end else if ($urandom_range(0, 2) == 0) begin
			out_stall <= 1'b1;
			stall_hold <= $urandom_range(0, 15);
		end
	end

	// Output checker: every result transfer is matched against the oldest owed answer.
	always @(posedge clk) begin
		answer_t owed;
		if (arst_n && out_valid && !out_stall) begin
			if (answer_q.size() == 0) begin
				flag_mismatch("result with nothing owed", event_count, 0);
			end else begin
				owed = answer_q.pop_front();
				if (accepted !== owed.accepted)
					flag_mismatch("accepted", accepted, owed.accepted);
				if (event_count !== owed.count)
					flag_mismatch("event_count", event_count, owed.count);
				if (fix_request !== owed.fix)
					flag_mismatch("fix_request", fix_request, owed.fix);
			end
		end
	end

	initial begin
		plan_row_t             plan [$];
		answer_t               none;
		int                    active_items;
		int                    phase;
		int                    n_items;
		int                    pick;
		int unsigned           span;
		logic [STAMP_W-1:0]    clock_ms;
		logic [CFG_DATA_W-1:0] d;
		logic                  o;
		logic                  deep;

		none = '0;

		// Directed plan. Fresh from reset everything is inactive.
		plan.push_back(item_row(OP_EVENT, 32'd0, 1'b1, 1'b0, 9'd0, 1'b0));
		plan.push_back(item_row(OP_QUERY, 32'hFFFF_FFFF, 1'b1, 1'b0, 9'd0, 1'b0));
		// Enabled, but min_events still zero.
		plan.push_back(reg_row(REG_ENABLE, 16'hFFFF));
		plan.push_back(item_row(OP_EVENT, 32'd5, 1'b1, 1'b0, 9'd0, 1'b0));
		// min_events 3 (upper data bits ignored), window still zero.
		plan.push_back(reg_row(REG_MIN_EVENTS, 16'hAA03));
		plan.push_back(item_row(OP_EVENT, 32'd5, 1'b1, 1'b0, 9'd0, 1'b0));
		// Two second window: three quick events trip the request.
		plan.push_back(reg_row(REG_WINDOW, 16'h0002));
		plan.push_back(item_row(OP_EVENT, 32'd0, 1'b1, 1'b1, 9'd1, 1'b0));
		plan.push_back(item_row(OP_EVENT, 32'd500, 1'b1, 1'b1, 9'd2, 1'b0));
		plan.push_back(item_row(OP_EVENT, 32'd1000, 1'b1, 1'b1, 9'd3, 1'b1));
		// Query consumes the request exactly once.
		plan.push_back(item_row(OP_QUERY, 32'd0, 1'b1, 1'b1, 9'd0, 1'b1));
		plan.push_back(item_row(OP_QUERY, 32'd0, 1'b1, 1'b1, 9'd0, 1'b0));
		// Window edge: 2999 ms is still two seconds, 3001 ms is three and drops out.
		plan.push_back(item_row(OP_EVENT, 32'd10000, 1'b1, 1'b1, 9'd1, 1'b0));
		plan.push_back(item_row(OP_EVENT, 32'd12999, 1'b1, 1'b1, 9'd2, 1'b0));
		plan.push_back(item_row(OP_EVENT, 32'd16000, 1'b1, 1'b1, 9'd1, 1'b0));
		// Counter wrap: stamps across the 32-bit boundary are only ms apart.
		plan.push_back(item_row(OP_EVENT, 32'hFFFF_FFFF, 1'b1, 1'b1, 9'd1, 1'b0));
		plan.push_back(item_row(OP_EVENT, 32'h0000_0100, 1'b1, 1'b1, 9'd2, 1'b0));
		plan.push_back(item_row(OP_EVENT, 32'h0000_0200, 1'b1, 1'b1, 9'd3, 1'b1));
		// Disable via bit 0 only; the pending request must survive.
		plan.push_back(reg_row(REG_ENABLE, 16'hFFFE));
		plan.push_back(item_row(OP_QUERY, 32'd0, 1'b1, 1'b0, 9'd0, 1'b0));
		plan.push_back(item_row(OP_EVENT, 32'd7, 1'b1, 1'b0, 9'd0, 1'b0));
		// Unused index must not disturb anything.
		plan.push_back(reg_row(REG_UNUSED, 16'hFFFF));
		plan.push_back(reg_row(REG_ENABLE, 16'h0001));
		plan.push_back(item_row(OP_QUERY, 32'd0, 1'b1, 1'b1, 9'd0, 1'b1));
		// Widest settings; a backward time step looks ancient after the wrap.
		plan.push_back(reg_row(REG_MIN_EVENTS, 16'h00FF));
		plan.push_back(reg_row(REG_WINDOW, 16'hFFFF));
		plan.push_back(item_row(OP_EVENT, 32'h8000_0000, 1'b1, 1'b1, 9'd1, 1'b0));
		plan.push_back(item_row(OP_QUERY, 32'h7FFF_FFFF, 1'b1, 1'b1, 9'd1, 1'b0));
		plan.push_back(item_row(OP_EVENT, 32'h7FFF_FFFF, 1'b1, 1'b1, 9'd1, 1'b0));
		// Single-event threshold; answers come from the shadow model.
		plan.push_back(reg_row(REG_MIN_EVENTS, 16'h0001));
		plan.push_back(item_row(OP_EVENT, 32'h5555_5555, 1'b0, 1'b0, 9'd0, 1'b0));
		plan.push_back(item_row(OP_QUERY, 32'hAAAA_AAAA, 1'b0, 1'b0, 9'd0, 1'b0));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_reg) begin
				settle();
				write_reg(plan[i].idx, plan[i].data);
			end else begin
				send_item(plan[i].op, plan[i].stamp, plan[i].typed, plan[i].want);
				if ($urandom_range(0, 2) == 0)
					pause_input($urandom_range(1, 16));
			end
		end

		// Random phases. The first one fills the ring to the top threshold with
		// stamps up to two seconds apart; later ones mix settings and time steps.
		phase = 0;
		active_items = 0;
		clock_ms = $urandom;
		while (active_items < RANDOM_ITEMS) begin
			settle();
			deep = (phase == 0);

			d = CFG_DATA_W'($urandom);
			d[0] = deep || ($urandom_range(0, 9) != 0);
			write_reg(REG_ENABLE, d);

			d = CFG_DATA_W'($urandom);
			pick = $urandom_range(0, 19);
			if (deep || pick == 1)
				d[MIN_W-1:0] = 8'd255;
			else if (pick == 0)
				d[MIN_W-1:0] = 8'd0;
			else if (pick <= 4)
				d[MIN_W-1:0] = MIN_W'($urandom_range(7, 40));
			else
				d[MIN_W-1:0] = MIN_W'($urandom_range(1, 6));
			write_reg(REG_MIN_EVENTS, d);

			pick = $urandom_range(0, 19);
			if (deep || pick == 1)
				d = 16'hFFFF;
			else if (pick == 0)
				d = 16'h0000;
			else if (pick <= 3)
				d = CFG_DATA_W'($urandom_range(0, 65535));
			else
				d = CFG_DATA_W'($urandom_range(1, 4));
			write_reg(REG_WINDOW, d);

			if ($urandom_range(0, 9) == 0)
				write_reg(REG_UNUSED, CFG_DATA_W'($urandom));

			n_items = deep ? 320 : $urandom_range(20, 80);
			repeat (n_items) begin
				o = ($urandom_range(0, 6) == 0) ? OP_QUERY : OP_EVENT;
				span = cfg_window * 1000;
				pick = $urandom_range(0, 19);
				if (deep)
					clock_ms += $urandom_range(0, 2000);
				else if (pick == 0)
					clock_ms = $urandom;                     // arbitrary jump
				else if (pick == 1)
					clock_ms -= $urandom_range(1, 5000);     // backward step, huge wrapped age
				else if (pick <= 4)
					clock_ms += span + $urandom_range(999, 1000);  // right at the window edge
				else
					clock_ms += $urandom_range(0,
						(2 * span + 2000) / (cfg_min == 0 ? 1 : cfg_min));
				active_items++;
				calm <= (active_items >= CALM_AFTER);
				send_item(o, clock_ms, 1'b0, none);
				if (!calm && $urandom_range(0, 3) == 0)
					pause_input($urandom_range(1, 16));
			end
			phase++;
		end

		// Drain, then give a stray result time to show up.
		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Watchdog: several times the slowest legal run.
	initial begin
		#60_000_000;
		$display("watchdog expired with %0d answers owed", answer_q.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/mewt_pkg.sv
hw/rtl/mewt_store.sv
hw/rtl/motion_event_window_trigger_unit.sv
tb/tb_motion_event_window_trigger_unit.sv
